// ===== rtl/avg_pkg.sv =====
// ----------------------------------------------------------------------------
// avg_pkg
// Shared widths, mode codes, rotation constants and the arctangent table
// for the arc vertex generator.
// ----------------------------------------------------------------------------
package avg_pkg;

	localparam int COORD_W = 24;
	localparam int RAD_W   = 23;
	localparam int ANG_W   = 16;
	localparam int SWEEP_W = 18;
	localparam int SEG_W   = 6;
	localparam int TRIG_W  = 32;
	localparam int Z_W     = 33;
	localparam int NUM_W   = 26;
	localparam int MAG_W   = 25;
	localparam int DEN_W   = SEG_W + 1;
	localparam int TABLE_LEN = 24;
	localparam int K_W     = 5;
	localparam int PROD_W  = RAD_W + 1 + TRIG_W;

	// request modes
	localparam logic [1:0] FUNC_OPEN   = 2'd0;
	localparam logic [1:0] FUNC_CLOSE  = 2'd1;
	localparam logic [1:0] FUNC_FILL   = 2'd2;
	localparam logic [1:0] FUNC_CIRCLE = 2'd3;

	// 1/K in Q30
	localparam logic signed [TRIG_W-1:0] INV_GAIN = 32'sd652032874;

	localparam logic signed [SWEEP_W-1:0] FULL_TURN = 18'sd65536;

	typedef struct packed {
		logic signed [TRIG_W-1:0] cos_v;
		logic signed [TRIG_W-1:0] sin_v;
	} trig_t;

	// atan(2^-k), 2^32 = one turn
	function automatic logic [31:0] atan_turn(input logic [K_W-1:0] k);
		logic [31:0] v;
		unique case (k)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/avg_div.sv =====
// ----------------------------------------------------------------------------
// avg_div
// Restoring divider, one quotient bit per cycle. Gives the low bits of
// floor(num / den) for a signed numerator and a positive denominator.
// ----------------------------------------------------------------------------
module avg_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [avg_pkg::NUM_W-1:0]   num,
	input  logic [avg_pkg::DEN_W-1:0]          den,
	output logic                               done,
	output logic [avg_pkg::ANG_W-1:0]          quot
);

	logic                          busy_q;
	logic                          done_q;
	logic [4:0]                    cnt_q;
	logic [avg_pkg::MAG_W-1:0]     mag_q;
	logic [avg_pkg::DEN_W-1:0]     rem_q;
	logic [avg_pkg::DEN_W-1:0]     den_q;
	logic                          neg_q;

	logic [avg_pkg::NUM_W-1:0]     num_abs;
	logic [avg_pkg::DEN_W:0]       wide;
	logic                          fits;
	logic [avg_pkg::DEN_W:0]       rem_wide;
	logic [avg_pkg::ANG_W-1:0]     q_lo;

	assign num_abs  = num[avg_pkg::NUM_W-1] ? avg_pkg::NUM_W'(-num) : avg_pkg::NUM_W'(num);
	assign wide     = {rem_q, mag_q[avg_pkg::MAG_W-1]};
	assign fits     = wide >= {1'b0, den_q};
	assign rem_wide = fits ? (wide - {1'b0, den_q}) : wide;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(avg_pkg::MAG_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= num_abs[avg_pkg::MAG_W-1:0];
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[avg_pkg::NUM_W-1];
		end else if (busy_q) begin
			mag_q <= {mag_q[avg_pkg::MAG_W-2:0], fits};
			rem_q <= rem_wide[avg_pkg::DEN_W-1:0];
		end
	end

	// floor for negative numerators: -Q when exact, -Q-1 otherwise
	assign q_lo = mag_q[avg_pkg::ANG_W-1:0];
	assign quot = neg_q ? (~q_lo + avg_pkg::ANG_W'(rem_q == '0)) : q_lo;
	assign done = done_q;

endmodule

// ===== rtl/avg_cordic.sv =====
// ----------------------------------------------------------------------------
// avg_cordic
// Rotation-mode CORDIC, one micro-rotation per cycle, giving cos and sin
// in Q30 of a 16-bit phase.
// ----------------------------------------------------------------------------
module avg_cordic #(
	parameter int ITERS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [avg_pkg::ANG_W-1:0]     phase,
	output logic                          done,
	output avg_pkg::trig_t                trig
);

	localparam int ITERS_EFF = (ITERS > avg_pkg::TABLE_LEN) ? avg_pkg::TABLE_LEN : ITERS;

	logic                                busy_q;
	logic                                done_q;
	logic [avg_pkg::K_W-1:0]             k_q;
	logic [1:0]                          quad_q;
	logic signed [avg_pkg::TRIG_W-1:0]   x_q;
	logic signed [avg_pkg::TRIG_W-1:0]   y_q;
	logic signed [avg_pkg::Z_W-1:0]      z_q;

	logic signed [avg_pkg::TRIG_W-1:0]   dx;
	logic signed [avg_pkg::TRIG_W-1:0]   dy;
	logic signed [avg_pkg::Z_W-1:0]      at;

	assign dx = y_q >>> k_q;
	assign dy = x_q >>> k_q;
	assign at = $signed({1'b0, avg_pkg::atan_turn(k_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (busy_q) begin
				k_q <= k_q + avg_pkg::K_W'(1);
				if (k_q == avg_pkg::K_W'(ITERS_EFF - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quad_q <= phase[avg_pkg::ANG_W-1 -: 2];
			z_q    <= $signed({3'b000, phase[avg_pkg::ANG_W-3:0], 16'h0000});
			x_q    <= avg_pkg::INV_GAIN;
			y_q    <= '0;
		end else if (busy_q) begin
			if (!z_q[avg_pkg::Z_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	// fold the first-quadrant result back to the full turn
	always_comb begin
		unique case (quad_q)
			2'd0: begin
				trig.cos_v = x_q;
				trig.sin_v = y_q;
			end
			2'd1: begin
				trig.cos_v = -y_q;
				trig.sin_v = x_q;
			end
			2'd2: begin
				trig.cos_v = -x_q;
				trig.sin_v = -y_q;
			end
			default: begin
				trig.cos_v = y_q;
				trig.sin_v = -x_q;
			end
		endcase
	end

	assign done = done_q;

endmodule

// ===== rtl/avg_place.sv =====
// ----------------------------------------------------------------------------
// avg_place
// Scales cos and sin by the radius through one shared multiplier, rounds,
// adds the center and saturates both coordinates.
// ----------------------------------------------------------------------------
module avg_place (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [avg_pkg::RAD_W-1:0]           radius,
	input  logic signed [avg_pkg::COORD_W-1:0]  center_x,
	input  logic signed [avg_pkg::COORD_W-1:0]  center_y,
	input  avg_pkg::trig_t                      trig,
	output logic                                done,
	output logic signed [avg_pkg::COORD_W-1:0]  vertex_x,
	output logic signed [avg_pkg::COORD_W-1:0]  vertex_y
);

	localparam int SH_W  = avg_pkg::PROD_W - 30;
	localparam int SUM_W = SH_W + 1;

	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_MX   = 2'd1;
	localparam logic [1:0] P_MY   = 2'd2;
	localparam logic [1:0] P_SY   = 2'd3;

	logic [1:0]                          step_q;
	logic                                done_q;
	logic signed [avg_pkg::PROD_W-1:0]   prod_q;
	logic signed [avg_pkg::COORD_W-1:0]  vx_q;
	logic signed [avg_pkg::COORD_W-1:0]  vy_q;

	logic signed [avg_pkg::RAD_W:0]      mul_a;
	logic signed [avg_pkg::TRIG_W-1:0]   mul_b;
	logic signed [avg_pkg::PROD_W-1:0]   prod;

	function automatic logic signed [avg_pkg::COORD_W-1:0] add_sat(
		input logic signed [avg_pkg::COORD_W-1:0] c,
		input logic signed [avg_pkg::PROD_W-1:0]  p
	);
		logic signed [avg_pkg::PROD_W-1:0] r;
		logic signed [SUM_W-1:0]           s;
		logic signed [SUM_W-1:0]           hi;
		logic signed [SUM_W-1:0]           lo;
		r  = p + avg_pkg::PROD_W'(64'sd536870912);
		s  = SUM_W'(c) + SUM_W'($signed(r[avg_pkg::PROD_W-1:30]));
		hi = SUM_W'(24'sh7fffff);
		lo = SUM_W'(24'sh800000);
		if (s > hi) begin
			return 24'sh7fffff;
		end else if (s < lo) begin
			return 24'sh800000;
		end
		return s[avg_pkg::COORD_W-1:0];
	endfunction

	assign mul_a = $signed({1'b0, radius});
	assign mul_b = (step_q == P_MY) ? trig.sin_v : trig.cos_v;
	// operands sign-extended so the full product is kept
	assign prod  = avg_pkg::PROD_W'(mul_a) * avg_pkg::PROD_W'(mul_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= P_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (step_q)
				P_IDLE: begin
					if (start) begin
						step_q <= P_MX;
					end
				end
				P_MX: step_q <= P_MY;
				P_MY: step_q <= P_SY;
				default: begin
					step_q <= P_IDLE;
					done_q <= 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step_q == P_MX || step_q == P_MY) begin
			prod_q <= prod;
		end
		if (step_q == P_MY) begin
			vx_q <= add_sat(center_x, prod_q);
		end
		if (step_q == P_SY) begin
			vy_q <= add_sat(center_y, prod_q);
		end
	end

	assign done     = done_q;
	assign vertex_x = vx_q;
	assign vertex_y = vy_q;

endmodule

// ===== rtl/arc_vertex_generator_core.sv =====
// ----------------------------------------------------------------------------
// arc_vertex_generator_core
// Turns one arc draw request into its polygon vertices, one vertex per
// output item, using a shared divider, a shared CORDIC and a shared
// multiplier under one sequencer.
//
//   channel  direction  handshake            payload
//   in       to core    in_valid / in_stall  func, center_x, center_y, radius,
//                                            start_angle, sweep_angle,
//                                            segment_count
//   out      from core  out_valid/out_stall  vertex_x, vertex_y, is_center,
//                                            is_last
//
// each arc vertex runs the divider for its angle offset (25 steps), then
// the CORDIC (one step per iteration), then the shared multiplier for x
// and y, with some sequencing between; a center vertex needs none of them
// a request of n segments gives n or n + 1 vertices; in_stall stays high
// until its last vertex is registered for output
// reset is asynchronous and clears only control: sequencers and output valid
// a stalled output holds its vertex; the sequencer waits at the next vertex
// ----------------------------------------------------------------------------
module arc_vertex_generator_core #(
	parameter int MAX_SEGMENTS     = 63,
	parameter int ANGLE_ITERATIONS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          func,
	input  logic signed [avg_pkg::COORD_W-1:0]  center_x,
	input  logic signed [avg_pkg::COORD_W-1:0]  center_y,
	input  logic [avg_pkg::RAD_W-1:0]           radius,
	input  logic [avg_pkg::ANG_W-1:0]           start_angle,
	input  logic signed [avg_pkg::SWEEP_W-1:0]  sweep_angle,
	input  logic [avg_pkg::SEG_W-1:0]           segment_count,

	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [avg_pkg::COORD_W-1:0]  vertex_x,
	output logic signed [avg_pkg::COORD_W-1:0]  vertex_y,
	output logic                                is_center,
	output logic                                is_last
);

	localparam logic [avg_pkg::SEG_W-1:0] SEG_MAX = avg_pkg::SEG_W'(MAX_SEGMENTS);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DIV      = 4'd1;
	localparam logic [3:0] S_DIV_WAIT = 4'd2;
	localparam logic [3:0] S_COR      = 4'd3;
	localparam logic [3:0] S_COR_WAIT = 4'd4;
	localparam logic [3:0] S_PLC      = 4'd5;
	localparam logic [3:0] S_PLC_WAIT = 4'd6;
	localparam logic [3:0] S_EMIT_ARC = 4'd7;
	localparam logic [3:0] S_EMIT_CTR = 4'd8;

	logic [3:0]                          state_q;

	logic [1:0]                          func_q;
	logic signed [avg_pkg::COORD_W-1:0]  cx_q;
	logic signed [avg_pkg::COORD_W-1:0]  cy_q;
	logic [avg_pkg::RAD_W-1:0]           rad_q;
	logic [avg_pkg::ANG_W-1:0]           start_q;
	logic signed [avg_pkg::SWEEP_W-1:0]  sweep_q;
	logic [avg_pkg::SEG_W-1:0]           n_q;
	logic [avg_pkg::SEG_W-1:0]           i_q;
	logic [avg_pkg::SEG_W-1:0]           last_q;
	logic signed [avg_pkg::NUM_W-1:0]    num_q;
	logic [avg_pkg::ANG_W-1:0]           phase_q;

	logic                                out_valid_q;
	logic signed [avg_pkg::COORD_W-1:0]  out_x_q;
	logic signed [avg_pkg::COORD_W-1:0]  out_y_q;
	logic                                out_ctr_q;
	logic                                out_last_q;

	logic                                accept;
	logic                                out_free;
	logic [avg_pkg::SEG_W-1:0]           n_eff;
	logic signed [avg_pkg::SWEEP_W-1:0]  sweep_sel;
	logic signed [avg_pkg::NUM_W-1:0]    num_init;
	logic signed [avg_pkg::NUM_W-1:0]    step2;

	logic                                div_done;
	logic [avg_pkg::ANG_W-1:0]           div_quot;
	logic                                cor_done;
	avg_pkg::trig_t                      cor_trig;
	logic                                plc_done;
	logic signed [avg_pkg::COORD_W-1:0]  plc_x;
	logic signed [avg_pkg::COORD_W-1:0]  plc_y;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		n_eff = segment_count;
		if (segment_count == '0) begin
			n_eff = avg_pkg::SEG_W'(1);
		end else if (segment_count > SEG_MAX) begin
			n_eff = SEG_MAX;
		end
	end

	assign sweep_sel = (func == avg_pkg::FUNC_CIRCLE) ? avg_pkg::FULL_TURN : sweep_angle;
	assign num_init  = ((func == avg_pkg::FUNC_FILL) ? (avg_pkg::NUM_W'(sweep_sel) <<< 1) : '0)
	                   + $signed(avg_pkg::NUM_W'(n_eff));
	assign step2     = avg_pkg::NUM_W'(sweep_q) <<< 1;

	avg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_DIV),
		.num    (num_q),
		.den    ({n_q, 1'b0}),
		.done   (div_done),
		.quot   (div_quot)
	);

	avg_cordic #(
		.ITERS (ANGLE_ITERATIONS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_COR),
		.phase  (phase_q),
		.done   (cor_done),
		.trig   (cor_trig)
	);

	avg_place u_place (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_PLC),
		.radius   (rad_q),
		.center_x (cx_q),
		.center_y (cy_q),
		.trig     (cor_trig),
		.done     (plc_done),
		.vertex_x (plc_x),
		.vertex_y (plc_y)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (func == avg_pkg::FUNC_FILL) ? S_EMIT_CTR : S_DIV;
					end
				end
				S_DIV: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (div_done) begin
						state_q <= S_COR;
					end
				end
				S_COR: state_q <= S_COR_WAIT;
				S_COR_WAIT: begin
					if (cor_done) begin
						state_q <= S_PLC;
					end
				end
				S_PLC: state_q <= S_PLC_WAIT;
				S_PLC_WAIT: begin
					if (plc_done) begin
						state_q <= S_EMIT_ARC;
					end
				end
				S_EMIT_ARC: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (i_q != last_q) begin
							state_q <= S_DIV;
						end else if (func_q == avg_pkg::FUNC_CLOSE) begin
							state_q <= S_EMIT_CTR;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_EMIT_CTR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= (func_q == avg_pkg::FUNC_CLOSE) ? S_IDLE : S_DIV;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request and vertex datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			cx_q    <= center_x;
			cy_q    <= center_y;
			rad_q   <= radius;
			start_q <= (func == avg_pkg::FUNC_CIRCLE) ? '0 : start_angle;
			sweep_q <= sweep_sel;
			n_q     <= n_eff;
			i_q     <= (func == avg_pkg::FUNC_FILL) ? avg_pkg::SEG_W'(1) : '0;
			last_q  <= (func == avg_pkg::FUNC_FILL) ? n_eff : (n_eff - avg_pkg::SEG_W'(1));
			num_q   <= num_init;
		end
		if (state_q == S_DIV_WAIT && div_done) begin
			phase_q <= start_q + div_quot;
		end
		if (state_q == S_EMIT_ARC && out_free) begin
			out_x_q    <= plc_x;
			out_y_q    <= plc_y;
			out_ctr_q  <= 1'b0;
			out_last_q <= (i_q == last_q) && (func_q != avg_pkg::FUNC_CLOSE);
			i_q        <= i_q + avg_pkg::SEG_W'(1);
			num_q      <= num_q + step2;
		end
		if (state_q == S_EMIT_CTR && out_free) begin
			out_x_q    <= cx_q;
			out_y_q    <= cy_q;
			out_ctr_q  <= 1'b1;
			out_last_q <= (func_q == avg_pkg::FUNC_CLOSE);
		end
	end

	assign out_valid = out_valid_q;
	assign vertex_x  = out_x_q;
	assign vertex_y  = out_y_q;
	assign is_center = out_ctr_q;
	assign is_last   = out_last_q;

endmodule

// ===== rtl/avg_checker.sv =====
// ----------------------------------------------------------------------------
// avg_checker
// Port-level checks on the arc vertex generator, bound to the core.
// ----------------------------------------------------------------------------
module avg_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic signed [avg_pkg::COORD_W-1:0]  vertex_x,
	input  logic signed [avg_pkg::COORD_W-1:0]  vertex_y,
	input  logic                                is_center,
	input  logic                                is_last
);

	// a stalled vertex stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(vertex_x) && $stable(vertex_y)
			&& $stable(is_center) && $stable(is_last)))
		else $error("stalled output item changed");

	// a taken request keeps the core busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("core not busy after accepting an item");

	// busy only starts with an accepted request
	a_busy_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid))
		else $error("core went busy without an item");

	// a vertex only appears while a request is in work
	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("output item with no request in work");

	// more vertices follow, so the request is still in work
	a_not_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !is_last) |-> in_stall)
		else $error("core idle before the last vertex");

endmodule

bind arc_vertex_generator_core avg_checker u_avg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.vertex_x  (vertex_x),
	.vertex_y  (vertex_y),
	.is_center (is_center),
	.is_last   (is_last)
);
